>>> hw/rtl/ffsc8_pkg.sv
// Shared types and constants for the frame sync unit with CRC-8 check.
`default_nettype none

package ffsc8_pkg;

   // Byte width of the serial stream and of every frame entry.
   localparam int BYTE_W = 8;

   // Default frame length in bytes, id byte and CRC byte included.
   localparam int FRAME_LEN_DEF = 10;

   // Number of leading frame positions that the decoder looks at.
   localparam int DEC_BYTES = 9;

   // Reset value of the expected device id.
   localparam logic [BYTE_W-1:0] ID_RESET = 8'h01;

   // Reflected CRC-8 polynomial, applied when shifting right.
   localparam logic [BYTE_W-1:0] CRC_POLY = 8'h8C;

   // Last bit position of a byte in the serial CRC.
   localparam logic [2:0] LAST_BIT = 3'd7;

   // Controls of the frame buffer.
   typedef struct packed {
      logic wr_en;
      logic shift;
   } buf_ctl_type;

   // Controls of the bit-serial CRC unit.
   typedef struct packed {
      logic clear;
      logic load;
      logic shift;
   } crc_ctl_type;

endpackage

`default_nettype wire

>>> hw/rtl/ffsc8_frame_buf.sv
// Frame buffer: byte store with indexed write and a one-byte shift toward the front.
`default_nettype none

module ffsc8_frame_buf #(
   parameter int FRAME_LEN = ffsc8_pkg::FRAME_LEN_DEF
) (
   input  wire                                            clock,
   input  ffsc8_pkg::buf_ctl_type                         ctl,
   input  wire  [$clog2(FRAME_LEN)-1:0]                   wr_idx,
   input  wire  [ffsc8_pkg::BYTE_W-1:0]                   wr_data,
   output logic [FRAME_LEN-1:0][ffsc8_pkg::BYTE_W-1:0]    bytes
);

   logic [FRAME_LEN-1:0][ffsc8_pkg::BYTE_W-1:0] store_ff;

   // A shift drops the front byte; a write places a received byte at the fill point.
   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         for (int k = 0; k < FRAME_LEN - 1; k++) begin
            store_ff[k] <= store_ff[k+1];
         end
      end else if (ctl.wr_en) begin
         store_ff[wr_idx] <= wr_data;
      end
   end

   assign bytes = store_ff;

endmodule

`default_nettype wire

>>> hw/rtl/ffsc8_crc_serial.sv
// Bit-serial CRC-8 (reflected polynomial 0x31, zero init) fed one bit per cycle while shift is set.
`default_nettype none

module ffsc8_crc_serial (
   input  wire                               clock,
   input  wire                               reset,
   input  ffsc8_pkg::crc_ctl_type            ctl,
   input  wire  [ffsc8_pkg::BYTE_W-1:0]      data_in,
   output logic [ffsc8_pkg::BYTE_W-1:0]      crc
);

   logic [ffsc8_pkg::BYTE_W-1:0] crc_ff;
   logic [ffsc8_pkg::BYTE_W-1:0] data_sr_ff;
   logic [ffsc8_pkg::BYTE_W-1:0] src_byte;
   logic                         feedback;

   // On a load the first bit comes straight from the new byte.
   assign src_byte = ctl.load ? data_in : data_sr_ff;
   assign feedback = crc_ff[0] ^ src_byte[0];

   // One CRC step per cycle while shift is set, least significant bit first.
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         crc_ff <= '0;
      end else if (ctl.shift) begin
         crc_ff <= (crc_ff >> 1) ^ (feedback ? ffsc8_pkg::CRC_POLY : '0);
      end
   end

   // Remaining bits of the byte being fed.
   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         data_sr_ff <= src_byte >> 1;
      end
   end

   assign crc = crc_ff;

endmodule

`default_nettype wire

>>> hw/rtl/feedback_frame_sync_crc8_unit.sv
// Top level of the reply frame hunter with bit-serial CRC-8 check and sliding resync.
//
//  Channel  Direction  Handshake               Word
//  req      in         req_valid / req_stall   req_rx_byte, req_flush
//  rsp      out        rsp_valid / rsp_stall   mode, torque, speed, position, fault
//  csr      in         csr_wr_en               csr_wr_data (expected id)
//
// A byte that does not complete a frame is taken while the unit is idle.
// The byte that completes a frame starts the serial CRC over the FRAME_LEN-1 checked
// bytes, bit by bit, and then a compare; on a mismatch the compare drops the front
// byte and resync steps drop bytes until an id byte leads. A finished result waits
// in an output register; the compare waits only while that register is full.
// Reset is synchronous.
`default_nettype none

module feedback_frame_sync_crc8_unit #(
   parameter int FRAME_LEN = ffsc8_pkg::FRAME_LEN_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire  [ffsc8_pkg::BYTE_W-1:0]        req_rx_byte,
   input  wire                                 req_flush,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic [7:0]                          rsp_mode_byte,
   output logic [15:0]                         rsp_torque_current,
   output logic signed [15:0]                  rsp_speed_rpm,
   output logic [15:0]                         rsp_position_value,
   output logic [7:0]                          rsp_fault_status,
   input  wire                                 csr_wr_en,
   input  wire  [ffsc8_pkg::BYTE_W-1:0]        csr_wr_data
);

   localparam int IDX_W = $clog2(FRAME_LEN);
   localparam int CNT_W = $clog2(FRAME_LEN + 1);
   localparam int NDEC  = (FRAME_LEN < ffsc8_pkg::DEC_BYTES) ? FRAME_LEN
                                                             : ffsc8_pkg::DEC_BYTES;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CRC,
      ST_CHECK,
      ST_RESYNC
   } state_type;

   state_type                                       state_ff;
   logic [CNT_W-1:0]                                fill_ff;
   logic [IDX_W-1:0]                                byte_idx_ff;
   logic [2:0]                                      bit_cnt_ff;
   logic [ffsc8_pkg::BYTE_W-1:0]                    id_ff;
   logic                                            rsp_valid_ff;
   logic [7:0]                                      mode_ff;
   logic [15:0]                                     torque_ff;
   logic [15:0]                                     speed_ff;
   logic [15:0]                                     position_ff;
   logic [7:0]                                      fault_ff;

   logic [FRAME_LEN-1:0][ffsc8_pkg::BYTE_W-1:0]     bytes;
   logic [ffsc8_pkg::DEC_BYTES-1:0][7:0]            dec;
   logic [ffsc8_pkg::BYTE_W-1:0]                    crc_value;
   ffsc8_pkg::buf_ctl_type                          buf_ctl;
   ffsc8_pkg::crc_ctl_type                          crc_ctl;
   logic                                            accept;
   logic                                            take;
   logic [CNT_W-1:0]                                fill_base;
   logic [CNT_W-1:0]                                fill_inc;
   logic                                            crc_match;
   logic                                            front_is_id;
   logic                                            rsp_free;
   logic                                            rsp_load;

   // Input handshake and the decision whether a byte enters the buffer.
   assign req_stall   = (state_ff != ST_IDLE);
   assign accept      = req_valid && !req_stall;
   assign fill_base   = req_flush ? '0 : fill_ff;
   assign fill_inc    = fill_base + 1'b1;
   assign take        = accept && !((fill_base == '0) && (req_rx_byte != id_ff));
   assign crc_match   = (crc_value == bytes[FRAME_LEN-1]);
   assign front_is_id = (bytes[0] == id_ff);
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;
   assign rsp_load    = (state_ff == ST_CHECK) && crc_match && rsp_free;

   // Buffer controls: write on a kept byte, shift on a failed check or during resync.
   always_comb begin
      buf_ctl.wr_en = take;
      buf_ctl.shift = ((state_ff == ST_CHECK) && !crc_match)
                   || ((state_ff == ST_RESYNC) && (fill_ff != '0) && !front_is_id);
   end

   // CRC controls: fresh start while idle, a new byte at each byte boundary.
   always_comb begin
      crc_ctl.clear = (state_ff == ST_IDLE);
      crc_ctl.load  = (state_ff == ST_CRC) && (bit_cnt_ff == '0);
      crc_ctl.shift = (state_ff == ST_CRC);
   end

   ffsc8_frame_buf #(
      .FRAME_LEN (FRAME_LEN)
   ) u_buf (
      .clock   (clock),
      .ctl     (buf_ctl),
      .wr_idx  (fill_base[IDX_W-1:0]),
      .wr_data (req_rx_byte),
      .bytes   (bytes)
   );

   ffsc8_crc_serial u_crc (
      .clock   (clock),
      .reset   (reset),
      .ctl     (crc_ctl),
      .data_in (bytes[byte_idx_ff]),
      .crc     (crc_value)
   );

   // Decoded positions beyond a short frame read as zero.
   always_comb begin
      dec = '0;
      for (int k = 0; k < NDEC; k++) begin
         dec[k] = bytes[k];
      end
   end

   // Sequencer, expected id register and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         byte_idx_ff  <= '0;
         bit_cnt_ff   <= '0;
         id_ff        <= ffsc8_pkg::ID_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            id_ff <= csr_wr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (take) begin
                  fill_ff <= fill_inc;
                  if (fill_inc == CNT_W'(FRAME_LEN)) begin
                     state_ff    <= ST_CRC;
                     byte_idx_ff <= '0;
                     bit_cnt_ff  <= '0;
                  end
               end else if (accept) begin
                  fill_ff <= fill_base;
               end
            end
            ST_CRC: begin
               bit_cnt_ff <= bit_cnt_ff + 1'b1;
               if (bit_cnt_ff == ffsc8_pkg::LAST_BIT) begin
                  if (byte_idx_ff == IDX_W'(FRAME_LEN - 2)) begin
                     state_ff <= ST_CHECK;
                  end else begin
                     byte_idx_ff <= byte_idx_ff + 1'b1;
                  end
               end
            end
            ST_CHECK: begin
               if (crc_match) begin
                  if (rsp_free) begin
                     mode_ff      <= dec[1];
                     torque_ff    <= {dec[2], dec[3]};
                     speed_ff     <= {dec[4], dec[5]};
                     position_ff  <= {dec[6], dec[7]};
                     fault_ff     <= dec[8];
                     fill_ff      <= '0;
                     state_ff     <= ST_IDLE;
                  end
               end else begin
                  fill_ff  <= CNT_W'(FRAME_LEN - 1);
                  state_ff <= ST_RESYNC;
               end
            end
            ST_RESYNC: begin
               if ((fill_ff == '0) || front_is_id) begin
                  state_ff <= ST_IDLE;
               end else begin
                  fill_ff <= fill_ff - 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_mode_byte      = mode_ff;
   assign rsp_torque_current = torque_ff;
   assign rsp_speed_rpm      = $signed(speed_ff);
   assign rsp_position_value = position_ff;
   assign rsp_fault_status   = fault_ff;

endmodule

`default_nettype wire

>>> hw/rtl/ffsc8_checker.sv
// Port-level checks of the frame sync unit and their binding to the top level.
`default_nettype none

module ffsc8_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_stall,
   input wire        rsp_valid,
   input wire        rsp_stall,
   input wire [7:0]  rsp_mode_byte,
   input wire [15:0] rsp_torque_current,
   input wire [15:0] rsp_speed_rpm,
   input wire [15:0] rsp_position_value,
   input wire [7:0]  rsp_fault_status
);

   // Reset leaves no result pending and the input open.
   a_reset_state: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("result pending or input stalled after reset");

   // A new result is produced only by the check, while the input is stalled.
   a_rsp_from_check: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared while bytes were being taken");

   // A stalled word stays valid.
   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result dropped while stalled");

   // A stalled word does not change.
   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(rsp_mode_byte) && $stable(rsp_torque_current)
         && $stable(rsp_speed_rpm) && $stable(rsp_position_value)
         && $stable(rsp_fault_status)))
      else $error("result changed while stalled");

endmodule

bind feedback_frame_sync_crc8_unit ffsc8_checker u_ffsc8_checker (.*);

`default_nettype wire
